// File: design/battery_charge_supervisor_unit_assert.svh
// Assertion macros shared by the supervisor RTL.
`ifndef BATTERY_CHARGE_SUPERVISOR_UNIT_ASSERT_SVH
`define BATTERY_CHARGE_SUPERVISOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bcs_pkg.sv
package bcs_pkg;

    localparam int TIME_W = 25;
    localparam int MS_W   = 16;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // item kinds
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_USB  = 2'd1;
    localparam logic [1:0] KIND_LOAD = 2'd2;

    // charger chip status
    localparam logic [1:0] CHIP_INIT     = 2'd0;
    localparam logic [1:0] CHIP_CHARGING = 2'd1;
    localparam logic [1:0] CHIP_DONE     = 2'd2;
    localparam logic [1:0] CHIP_FAULT    = 2'd3;

    // battery voltage status
    localparam logic [1:0] VOLT_OK   = 2'd0;
    localparam logic [1:0] VOLT_LOW  = 2'd1;
    localparam logic [1:0] VOLT_CRIT = 2'd2;

    // charge states
    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_CHARGING   = 3'd1;
    localparam logic [2:0] ST_DONE       = 3'd2;
    localparam logic [2:0] ST_LOW        = 3'd3;
    localparam logic [2:0] ST_CRITICAL   = 3'd4;
    localparam logic [2:0] ST_TEMP_FAULT = 3'd5;
    localparam logic [2:0] ST_CHG_FAULT  = 3'd6;

    // indicator effects
    localparam logic [1:0] IND_OFF   = 2'd0;
    localparam logic [1:0] IND_WHITE = 2'd1;
    localparam logic [1:0] IND_RED   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_CHARGE_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_CHARGE_SETTLE  = 2'd1;
    localparam logic [1:0] CFG_BATT_SETTLE    = 2'd2;

    localparam logic [TIME_W-1:0] CHARGE_TIMEOUT_RST = 25'd28800000;
    localparam logic [MS_W-1:0]   CHARGE_SETTLE_RST  = 16'd500;
    localparam logic [MS_W-1:0]   BATT_SETTLE_RST    = 16'd100;

    typedef struct packed {
        logic       fast;
        logic [1:0] ind;
        logic [2:0] st;
    } t_snap;

    typedef struct packed {
        logic              usb_mode;
        logic              load_on;
        logic              out_enabled;
        logic              volt_poll_on;
        logic [MS_W-1:0]   batt_settle_left;
        logic [MS_W-1:0]   chip_settle_left;
        logic              fault_latch;
        logic              timeout_hit;
        logic              charging_on;
        logic [TIME_W-1:0] charge_time;
        t_snap             cur_snap;
        t_snap             last_snap;
        logic              snap_seen;
        logic [1:0]        last_level;
        logic              mode_dirty;
    } t_state;

    typedef struct packed {
        logic  rep;
        logic  volt;
        logic  path;
        t_snap rep_snap;
    } t_flags;

    typedef struct packed {
        t_state s;
        t_flags f;
    } t_work;

    typedef struct packed {
        logic [1:0]      kind;
        logic [MS_W-1:0] elapsed;
        logic            usb;
        logic            load;
        logic            temp_ok;
        logic [1:0]      volt;
        logic [1:0]      chip;
    } t_item;

    typedef struct packed {
        logic [TIME_W-1:0] charge_timeout;
        logic [MS_W-1:0]   charge_settle;
        logic [MS_W-1:0]   batt_settle;
    } t_cfg;

endpackage

// File: design/battery_charge_supervisor_unit.sv
// Flow: an accepted word is held in the input register, passes the state-update step and
// is written to the result register, where it stays valid until the sink takes it.
// Throughput: one word per cycle while the sink keeps m_axis_tready high; the single
// state-update stage between the input register and the result register sets this rate.
// Reset (i_rst_n, synchronous, low): supervisor state cleared, configuration back to
// 28800000 / 500 / 100 ms, both handshake stages emptied.
module battery_charge_supervisor_unit
    import bcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [15:0] elapsed_ms, [16] usb_connected, [17] load_active, [18] temp_ok,
    // [20:19] volt_status, [22:21] chip_status, [23] zero
    input  logic [23:0]       s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]        s_axis_tuser,

    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [0] usb_mode, [1] charge_enable, [2] fast_charge, [3] battery_out_enable,
    // [6:4] charge_state, [8:7] indicator, [9] status_report, [11:10] volt_level,
    // [12] volt_report, [13] path_ready, [15:14] zero
    output logic [15:0]       m_axis_tdata,

    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_addr,
    input  logic [TIME_W-1:0] i_cfg_data
);

    `include "battery_charge_supervisor_unit_assert.svh"

    logic        r_in_valid;
    logic [1:0]  r_in_kind;
    logic [22:0] r_in_data;
    logic        r_out_valid;
    logic [15:0] r_out_data;
    logic [15:0] n_out_data;
    t_state      r_st;
    t_state      n_st;
    t_cfg        r_cfg;
    t_item       item;
    logic        proc_fire;

    // ---------------------------------------------------------------- helpers

    function automatic logic chip_readable(input t_state s);
        return s.charging_on && (s.chip_settle_left == '0);
    endfunction

    function automatic logic [1:0] chip_read(input t_state s, input t_item it);
        return chip_readable(s) ? it.chip : CHIP_INIT;
    endfunction

    function automatic t_snap build_snapshot(input t_state s, input logic valid,
                                             input logic [1:0] chip, input t_item it);
        logic [2:0] st;
        t_snap      r;
        if (s.fault_latch)                      st = ST_CHG_FAULT;
        else if (!it.temp_ok)                   st = ST_TEMP_FAULT;
        else if (valid && chip == CHIP_FAULT)   st = ST_CHG_FAULT;
        else if (valid && it.volt == VOLT_CRIT) st = ST_CRITICAL;
        else if (valid && chip == CHIP_CHARGING) st = ST_CHARGING;
        else if (valid && chip == CHIP_DONE)    st = ST_DONE;
        else if (valid && it.volt == VOLT_LOW)  st = ST_LOW;
        else if (s.timeout_hit)                 st = ST_DONE;
        else if (s.charging_on)                 st = ST_CHARGING;
        else                                    st = ST_IDLE;
        if (s.timeout_hit && st == ST_CHARGING) st = ST_DONE;
        r.st = st;
        if (st >= ST_CRITICAL)     r.ind = IND_RED;
        else if (st == ST_CHARGING) r.ind = IND_WHITE;
        else                        r.ind = IND_OFF;
        r.fast = !s.load_on;
        return r;
    endfunction

    function automatic t_state update_charge(input t_state s_in, input t_item it,
                                             input t_cfg c);
        t_state     s;
        logic       readable;
        logic [1:0] chip;
        logic       allow;
        logic       was;
        s        = s_in;
        readable = chip_readable(s);
        chip     = chip_read(s, it);
        if (readable && chip == CHIP_FAULT) s.fault_latch = 1'b1;
        allow = it.temp_ok && !s.fault_latch && !s.timeout_hit;
        if (allow && readable) begin
            if (chip == CHIP_DONE || chip == CHIP_FAULT) allow = 1'b0;
            else if (it.volt == VOLT_CRIT)               allow = 1'b0;
        end
        was           = s.charging_on;
        s.charging_on = allow;
        if (allow && !was) s.chip_settle_left = c.charge_settle;
        else if (!allow)   s.chip_settle_left = '0;
        s.cur_snap = build_snapshot(s, chip_readable(s), chip_read(s, it), it);
        return s;
    endfunction

    function automatic t_work evaluate(input t_work w_in);
        t_work w;
        logic  changed;
        w = w_in;
        if (w.s.usb_mode) begin
            changed = !w.s.snap_seen || (w.s.cur_snap[4:0] != w.s.last_snap[4:0]);
            if (changed) begin
                w.f.rep      = 1'b1;
                w.f.rep_snap = w.s.cur_snap;
                w.s.last_snap = w.s.cur_snap;
                w.s.snap_seen = 1'b1;
            end else if (w.s.cur_snap.fast != w.s.last_snap.fast) begin
                // fast flag alone changes silently
                w.s.last_snap = w.s.cur_snap;
                w.s.snap_seen = 1'b1;
            end
        end
        return w;
    endfunction

    function automatic t_work apply_battery(input t_work w_in, input t_cfg c);
        t_work w;
        w = w_in;
        w.s.volt_poll_on = w.s.load_on;
        if (w.s.load_on) begin
            if (!w.s.out_enabled) begin
                w.s.out_enabled      = 1'b1;
                w.s.batt_settle_left = c.batt_settle;
                w.f.path             = 1'b1;
            end
        end else begin
            w.s.batt_settle_left = '0;
            w.s.out_enabled      = 1'b0;
        end
        return w;
    endfunction

    function automatic t_work apply_usb(input t_work w_in, input t_item it, input t_cfg c);
        t_work w;
        w = w_in;
        w.s.out_enabled      = 1'b0;
        w.s.batt_settle_left = '0;
        w.s.volt_poll_on     = 1'b0;
        w.s                  = update_charge(w.s, it, c);
        w                    = evaluate(w);
        w.f.path             = 1'b1;
        return w;
    endfunction

    function automatic t_work clear_indicator(input t_work w_in);
        t_work w;
        w = w_in;
        if (w.s.snap_seen) begin
            w.f.rep      = 1'b1;
            w.f.rep_snap = '0;
        end
        w.s.last_snap        = '0;
        w.s.snap_seen        = 1'b0;
        w.s.cur_snap         = '0;
        w.s.fault_latch      = 1'b0;
        w.s.chip_settle_left = '0;
        w.s.charge_time      = '0;
        w.s.timeout_hit      = 1'b0;
        return w;
    endfunction

    function automatic t_work poll_battery(input t_work w_in, input t_item it);
        t_work      w;
        logic [1:0] level;
        w = w_in;
        if (it.volt == VOLT_CRIT)     level = VOLT_CRIT;
        else if (it.volt == VOLT_LOW) level = VOLT_LOW;
        else                          level = VOLT_OK;
        if (!w.s.usb_mode && level != w.s.last_level) begin
            w.s.last_level = level;
            w.f.volt       = 1'b1;
            if (level == VOLT_CRIT) begin
                w.s.out_enabled  = 1'b0;
                w.s.volt_poll_on = 1'b0;
            end
        end
        return w;
    endfunction

    function automatic t_state charge_timer(input t_state s_in, input t_item it,
                                            input t_cfg c);
        t_state        s;
        logic [1:0]    chip;
        logic [TIME_W:0] sum;
        s    = s_in;
        chip = chip_read(s, it);
        sum  = {1'b0, s.charge_time} + (TIME_W+1)'(it.elapsed);
        if (!s.usb_mode) begin
            s.charge_time = '0;
            s.timeout_hit = 1'b0;
        end else if (!s.timeout_hit && s.charging_on) begin
            if (chip == CHIP_DONE) begin
                s.charge_time = '0;
                s.timeout_hit = 1'b0;
            end else if (chip != CHIP_FAULT) begin
                // saturate at full scale
                if (sum[TIME_W]) s.charge_time = TIME_MAX;
                else             s.charge_time = sum[TIME_W-1:0];
                if (s.charge_time >= c.charge_timeout) s.timeout_hit = 1'b1;
            end
        end
        return s;
    endfunction

    function automatic logic [MS_W-1:0] count_down(input logic [MS_W-1:0] left,
                                                   input logic [MS_W-1:0] elapsed);
        return (elapsed >= left) ? '0 : left - elapsed;
    endfunction

    // ---------------------------------------------------------------- handshake

    assign proc_fire     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || proc_fire;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign o_cfg_ready   = 1'b1;

    assign item.kind    = r_in_kind;
    assign item.elapsed = r_in_data[15:0];
    assign item.usb     = r_in_data[16];
    assign item.load    = r_in_data[17];
    assign item.temp_ok = r_in_data[18];
    assign item.volt    = r_in_data[20:19];
    assign item.chip    = r_in_data[22:21];

    // ---------------------------------------------------------------- item step

    always_comb begin
        t_work w;
        t_snap shown;
        w.s = r_st;
        w.f = '0;
        case (item.kind)
            KIND_TICK: begin
                if (w.s.mode_dirty) begin
                    w.s.mode_dirty = 1'b0;
                    if (w.s.usb_mode) w = apply_usb(w, item, r_cfg);
                    else              w = apply_battery(w, r_cfg);
                end
                if (!w.s.usb_mode) begin
                    w.s.batt_settle_left = count_down(w.s.batt_settle_left, item.elapsed);
                    if (w.s.volt_poll_on && w.s.batt_settle_left == '0)
                        w = poll_battery(w, item);
                    w = apply_battery(w, r_cfg);
                end
                if (w.s.usb_mode) begin
                    w.s.chip_settle_left = count_down(w.s.chip_settle_left, item.elapsed);
                    w.s = charge_timer(w.s, item, r_cfg);
                    w.s = update_charge(w.s, item, r_cfg);
                    w   = evaluate(w);
                end
            end
            KIND_USB: begin
                if (item.usb) begin
                    w.s.usb_mode         = 1'b1;
                    w.s.fault_latch      = 1'b0;
                    w.s.chip_settle_left = r_cfg.charge_settle;
                    w.s.out_enabled      = 1'b0;
                    w = apply_usb(w, item, r_cfg);
                end else begin
                    w.s.usb_mode         = 1'b0;
                    w.s.fault_latch      = 1'b0;
                    w.s.chip_settle_left = '0;
                    w.s.charging_on      = 1'b0;
                    w = clear_indicator(w);
                    w = apply_battery(w, r_cfg);
                end
                w.s.mode_dirty = 1'b1;
            end
            KIND_LOAD: begin
                if (w.s.load_on != item.load) begin
                    w.s.load_on = item.load;
                    if (!w.s.usb_mode) begin
                        w = apply_battery(w, r_cfg);
                    end else begin
                        w.s = update_charge(w.s, item, r_cfg);
                        w   = evaluate(w);
                    end
                end
            end
            default: ;
        endcase

        shown = w.f.rep ? w.f.rep_snap : w.s.cur_snap;
        n_st  = w.s;
        n_out_data = {2'b00, w.f.path, w.f.volt, w.s.last_level, w.f.rep, shown.ind,
                      shown.st, w.s.out_enabled, w.s.charging_on && !w.s.load_on,
                      w.s.charging_on, w.s.usb_mode};
    end

    // ---------------------------------------------------------------- registers

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= '0;
            r_cfg.charge_timeout <= CHARGE_TIMEOUT_RST;
            r_cfg.charge_settle  <= CHARGE_SETTLE_RST;
            r_cfg.batt_settle    <= BATT_SETTLE_RST;
        end else begin
            if (s_axis_tready) r_in_valid <= s_axis_tvalid;
            // hold a finished word until the sink takes it
            if (proc_fire)          r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
            if (proc_fire) r_st <= n_st;
            if (i_cfg_valid) begin
                case (i_cfg_addr)
                    CFG_CHARGE_TIMEOUT: r_cfg.charge_timeout <= i_cfg_data;
                    CFG_CHARGE_SETTLE:  r_cfg.charge_settle  <= i_cfg_data[MS_W-1:0];
                    CFG_BATT_SETTLE:    r_cfg.batt_settle    <= i_cfg_data[MS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_kind <= s_axis_tuser;
            r_in_data <= s_axis_tdata[22:0];
        end
        if (proc_fire) r_out_data <= n_out_data;
    end

    // ---------------------------------------------------------------- checks

    `BCS_ASSERT_NOW(a_usb_no_batt_out, r_st.usb_mode, !r_st.out_enabled,
        "battery output enabled in usb mode")
    `BCS_ASSERT_NOW(a_charge_needs_usb, r_st.charging_on, r_st.usb_mode,
        "charging enabled in battery mode")
    `BCS_ASSERT_NOW(a_timeout_stops_charge, r_st.timeout_hit, !r_st.charging_on,
        "charging still enabled after timeout")
    `BCS_ASSERT_NOW(a_poll_needs_load, r_st.volt_poll_on, r_st.load_on,
        "voltage polling active with load off")
    `BCS_ASSERT_NEXT(a_step_gives_result, proc_fire, r_out_valid,
        "processed word produced no result")

endmodule
